// ----- src/esd_pkg.sv -----
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, constants and helper functions for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

	// Field widths.
	localparam int unsigned CodeW  = 21;
	localparam int unsigned ValW   = 9;
	localparam int unsigned CntW   = 2;

	// Character codes that the decoder recognizes.
	localparam logic [CodeW-1:0] CpBackslash = 21'h00005C;
	localparam logic [CodeW-1:0] CpLowerX    = 21'h000078;
	localparam logic [CodeW-1:0] CpAsciiEnd  = 21'h000080;

	// Decoder mode.
	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_OCT   = 2'd2,
		MODE_HEX   = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_HEX   = 2'd1,
		ST_NON_ASCII = 2'd2
	} status_t;

	// Decoder state carried from one item to the next.
	typedef struct packed {
		mode_t             mode;
		logic [CntW-1:0]   cnt;
		logic [ValW-1:0]   val;
		status_t           err;
		logic              raw;
		logic              start;
	} dec_state_t;

	// One result item.
	typedef struct packed {
		logic [CodeW-1:0]  code;
		logic              eos;
		status_t           status;
	} result_t;

	// Results caused by one input item: a count of zero to two and the items.
	typedef struct packed {
		logic [1:0]        n;
		result_t           r0;
		result_t           r1;
	} dec_out_t;

	// Hex digit value: bit 4 is set when the code point is a hex digit.
	function automatic logic [4:0] hex_digit(input logic [CodeW-1:0] cp);
		logic [4:0] h;
		h = 5'd0;
		if (cp >= 21'h30 && cp <= 21'h39) begin
			h = {1'b1, cp[3:0]};
		end else if ((cp >= 21'h41 && cp <= 21'h46) || (cp >= 21'h61 && cp <= 21'h66)) begin
			h = {1'b1, 4'(cp[3:0] + 4'd9)};
		end
		return h;
	endfunction

endpackage

// ----- src/esd_if.sv -----
// ----------------------------------------------------------------------------
// esd_in_if / esd_out_if
// Valid/ready channels for code points in and decoded results out.
// ----------------------------------------------------------------------------
interface esd_in_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        last;
	logic        raw;

	modport source (output valid, output code_point, output last, output raw, input ready);
	modport sink   (input valid, input code_point, input last, input raw, output ready);
endinterface

interface esd_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] out_code;
	logic        end_of_string;
	logic [1:0]  status;

	modport source (output valid, output out_code, output end_of_string, output status,
		input ready);
	modport sink   (input valid, input out_code, input end_of_string, input status,
		output ready);
endinterface

// ----- src/escape_sequence_decoder_core.sv -----
// A result is written to the result queue and offered from the queue head.
// Throughput: one code point per cycle while input ready is high; an escape that yields
// two results is absorbed by the four-entry result queue.
// Input ready depends only on the queue fill (room for two results), never on output ready.
// Reset (arst_n low) empties the queue and sets the decoder to the start of a new string.
// ----------------------------------------------------------------------------
// escape_sequence_decoder_core
// Decodes C-style backslash escapes in a stream of code points, one per cycle while ready.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_core
	import esd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	esd_in_if.sink         din,
	esd_out_if.source      dout
);

	localparam int unsigned QDepth = 4;

	dec_state_t  st_q;
	dec_state_t  nxt;
	dec_out_t    res;
	result_t     queue_q [QDepth];
	logic [1:0]  wr_q;
	logic [1:0]  rd_q;
	logic [2:0]  count_q;
	logic        acc;
	logic        pop;
	logic [1:0]  push_n;

	esd_decode u_decode (
		.st         (st_q),
		.code_point (din.code_point),
		.last       (din.last),
		.raw        (din.raw),
		.nxt        (nxt),
		.res        (res)
	);

	// Handshake: accept while the queue has room for two results.
	assign din.ready = (count_q <= 3'd2);
	assign acc       = din.valid && din.ready;
	assign pop       = dout.valid && dout.ready;
	assign push_n    = acc ? res.n : 2'd0;

	// Decoder state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_PLAIN, cnt: '0, val: '0, err: ST_OK, raw: 1'b0,
				start: 1'b1};
		end else if (acc) begin
			st_q <= nxt;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push_n;
			rd_q    <= rd_q + 2'(pop);
			count_q <= count_q + 3'(push_n) - 3'(pop);
		end
	end

	// Result queue payload.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_q] <= res.r0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_q + 2'd1] <= res.r1;
		end
	end

	// Output transfer from the queue head.
	assign dout.valid         = (count_q != 3'd0);
	assign dout.out_code      = queue_q[rd_q].code;
	assign dout.end_of_string = queue_q[rd_q].eos;
	assign dout.status        = queue_q[rd_q].status;

	// The fill count never exceeds the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(QDepth))
		else $error("result queue overflow");

	// The fill count tracks pushes and pops exactly.
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + 3'($past(push_n)) - 3'($past(pop)))
		else $error("result queue count mismatch");

	// The last item of a string always returns the decoder to string start.
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && din.last |=> st_q.start && st_q.err == ST_OK && st_q.mode == MODE_PLAIN)
		else $error("decoder did not restart after end of string");

	// A raw string never records an error status and never leaves plain mode.
	a_raw_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.start && st_q.raw |-> st_q.err == ST_OK && st_q.mode == MODE_PLAIN)
		else $error("raw string entered escape or error state");

endmodule

// ----- src/esd_decode.sv -----
// ----------------------------------------------------------------------------
// esd_decode
// Combinational decode of one code point against the current decoder state.
// ----------------------------------------------------------------------------
module esd_decode
	import esd_pkg::*;
(
	input  dec_state_t       st,
	input  logic [CodeW-1:0] code_point,
	input  logic             last,
	input  logic             raw,
	output dec_state_t       nxt,
	output dec_out_t         res
);

	dec_state_t       cur;
	logic             ctl_hit;
	logic [6:0]       ctl_code;
	logic             is_oct;
	logic [4:0]       hx;
	logic [ValW-1:0]  oct_val;

	// Control escapes that map straight to a single code.
	always_comb begin
		ctl_hit  = 1'b1;
		ctl_code = 7'd0;
		case (code_point)
			21'h61:  ctl_code = 7'd7;
			21'h62:  ctl_code = 7'd8;
			21'h66:  ctl_code = 7'd12;
			21'h6E:  ctl_code = 7'd10;
			21'h72:  ctl_code = 7'd13;
			21'h74:  ctl_code = 7'd9;
			21'h76:  ctl_code = 7'd11;
			21'h5C:  ctl_code = 7'h5C;
			default: ctl_hit  = 1'b0;
		endcase
	end

	assign is_oct  = code_point inside {[21'h30:21'h37]};
	assign hx      = hex_digit(code_point);
	assign oct_val = {cur.val[ValW-4:0], code_point[2:0]};

	// Main decode: next state and up to two results.
	always_comb begin
		cur = st;
		if (st.start) begin
			cur.raw  = raw;
			cur.mode = MODE_PLAIN;
			cur.cnt  = '0;
			cur.val  = '0;
			cur.err  = ST_OK;
		end
		nxt   = cur;
		res.n  = 2'd0;
		res.r0 = '{code: '0, eos: 1'b0, status: ST_OK};
		res.r1 = '{code: '0, eos: 1'b0, status: ST_OK};

		if (cur.err != ST_OK) begin
			// Discarding the rest of a failed string; the last item repeats the error.
			if (last) begin
				res.n  = 2'd1;
				res.r0 = '{code: '0, eos: 1'b1, status: cur.err};
			end
		end else if (cur.raw) begin
			res.n  = 2'd1;
			res.r0 = '{code: code_point, eos: last, status: ST_OK};
		end else begin
			case (cur.mode)
				MODE_ESC: begin
					nxt.mode = MODE_PLAIN;
					if (ctl_hit) begin
						res.n  = 2'd1;
						res.r0 = '{code: CodeW'(ctl_code), eos: last, status: ST_OK};
					end else if (is_oct) begin
						nxt.val = ValW'(code_point[2:0]);
						nxt.cnt = CntW'(1);
						if (last) begin
							res.n  = 2'd1;
							res.r0 = '{code: CodeW'(code_point[2:0]), eos: 1'b1,
								status: ST_OK};
						end else begin
							nxt.mode = MODE_OCT;
						end
					end else if (code_point == CpLowerX) begin
						if (last) begin
							nxt.err = ST_BAD_HEX;
							res.n   = 2'd1;
							res.r0  = '{code: '0, eos: 1'b1, status: ST_BAD_HEX};
						end else begin
							nxt.mode = MODE_HEX;
							nxt.cnt  = '0;
							nxt.val  = '0;
						end
					end else if (code_point >= CpAsciiEnd) begin
						nxt.err = ST_NON_ASCII;
						res.n   = 2'd1;
						res.r0  = '{code: '0, eos: last, status: ST_NON_ASCII};
					end else begin
						// Unknown escape: backslash, then the character itself.
						res.n  = 2'd2;
						res.r0 = '{code: CpBackslash, eos: 1'b0, status: ST_OK};
						res.r1 = '{code: code_point, eos: last, status: ST_OK};
					end
				end
				MODE_OCT: begin
					if (is_oct) begin
						nxt.val = oct_val;
						nxt.cnt = cur.cnt + CntW'(1);
						if (cur.cnt == CntW'(2) || last) begin
							res.n    = 2'd1;
							res.r0   = '{code: CodeW'(oct_val), eos: last, status: ST_OK};
							nxt.mode = MODE_PLAIN;
						end
					end else begin
						// The octal run ends; the character is then plain text, or a backslash starts a new escape.
						res.r0   = '{code: CodeW'(cur.val), eos: 1'b0, status: ST_OK};
						nxt.mode = MODE_PLAIN;
						if (code_point == CpBackslash && !last) begin
							res.n    = 2'd1;
							nxt.mode = MODE_ESC;
						end else begin
							res.n  = 2'd2;
							res.r1 = '{code: code_point, eos: last, status: ST_OK};
						end
					end
				end
				MODE_HEX: begin
					if (!hx[4] || (cur.cnt == '0 && last)) begin
						nxt.err  = ST_BAD_HEX;
						nxt.mode = MODE_PLAIN;
						res.n    = 2'd1;
						res.r0   = '{code: '0, eos: last, status: ST_BAD_HEX};
					end else if (cur.cnt == '0) begin
						nxt.val = ValW'(hx[3:0]);
						nxt.cnt = CntW'(1);
					end else begin
						res.n    = 2'd1;
						res.r0   = '{code: CodeW'({cur.val[3:0], hx[3:0]}), eos: last,
							status: ST_OK};
						nxt.mode = MODE_PLAIN;
					end
				end
				default: begin
					if (code_point == CpBackslash && !last) begin
						nxt.mode = MODE_ESC;
					end else begin
						res.n  = 2'd1;
						res.r0 = '{code: code_point, eos: last, status: ST_OK};
					end
				end
			endcase
		end

		// The end of a string returns the state to its start values.
		if (last) begin
			nxt.mode  = MODE_PLAIN;
			nxt.cnt   = '0;
			nxt.val   = '0;
			nxt.err   = ST_OK;
			nxt.start = 1'b1;
		end else begin
			nxt.start = 1'b0;
		end
	end

endmodule
